[hw/rtl/serial_angle_pair_to_servo_pulse_assert.svh]
// Assertion macros for the serial angle pair block.
`ifndef SERIAL_ANGLE_PAIR_TO_SERVO_PULSE_ASSERT_SVH
`define SERIAL_ANGLE_PAIR_TO_SERVO_PULSE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SAP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define SAP_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define SAP_ASSERT_ALWAYS(label, cond)
`define SAP_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

[hw/rtl/sap_pkg.sv]
package sap_pkg;

  localparam int LineBufferBytes = 32;
  localparam int LenW = $clog2(LineBufferBytes);
  localparam logic [LenW-1:0] LineMaxLen = LenW'(LineBufferBytes - 1);

  localparam int QueueDepth = 4;
  localparam int QueueAw = $clog2(QueueDepth);

  localparam int CfgW = 15;
  localparam int AngleW = 8;
  localparam int PulseW = 16;
  localparam int ProdW = CfgW + AngleW;
  localparam int RecipW = 24;
  localparam int DivShift = 31;
  localparam logic [RecipW-1:0] Recip180 = 24'd11930465;

  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChPlus = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChComma = 8'd44;
  localparam logic [7:0] ChZero = 8'd48;
  localparam logic [7:0] ChNine = 8'd57;

  localparam logic [AngleW-1:0] AngleMax = 8'd180;
  localparam logic [AngleW-1:0] AngleReset = 8'd90;
  localparam logic [PulseW-1:0] PulseReset = 16'd1500;
  localparam logic [CfgW-1:0] PulseMinReset = 15'd500;
  localparam logic [CfgW-1:0] PulseSpanReset = 15'd2000;

  localparam logic [1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [1:0] CFG_PULSE_SPAN = 2'd1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_SKIP1,
    PH_SIGN1,
    PH_DIG1,
    PH_SKIP2,
    PH_SIGN2,
    PH_DIG2,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    status_t status;
    logic [AngleW-1:0] pan;
    logic [AngleW-1:0] tilt;
  } line_rec_t;

  function automatic logic [PulseW-1:0] div180(input logic [ProdW-1:0] x);
    logic [ProdW+RecipW-1:0] p;
    p = (ProdW+RecipW)'(x) * (ProdW+RecipW)'(Recip180);
    return p[DivShift +: PulseW];
  endfunction

endpackage

[hw/rtl/sap_front.sv]
module sap_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  input  logic [7:0]         rx_byte,
  output logic               rx_ready,
  input  logic               full,
  output logic               push,
  output sap_pkg::line_rec_t rec
);
  import sap_pkg::*;

  phase_t phase, phase_next;
  logic [LenW-1:0] len, len_next;
  logic [AngleW-1:0] mag1, mag1_next, mag2, mag2_next;
  logic neg1, neg1_next, neg2, neg2_next;
  logic is_nl, is_space, is_digit, is_sign;
  logic [3:0] dval;

  function automatic logic [AngleW-1:0] add_digit(input logic [AngleW-1:0] mag,
                                                  input logic [3:0] d);
    logic [11:0] v;
    v = 12'(mag) * 12'd10 + 12'(d);
    return (v > 12'd255) ? 8'd255 : v[AngleW-1:0];
  endfunction

  function automatic logic angle_ok(input logic [AngleW-1:0] mag, input logic neg);
    return (mag == '0) || (!neg && mag <= AngleMax);
  endfunction

  assign rx_ready = !full;
  assign is_nl = (rx_byte == ChNewline);
  assign is_space = (rx_byte == ChSpace) || (rx_byte >= ChTab && rx_byte <= ChCr);
  assign is_digit = (rx_byte >= ChZero) && (rx_byte <= ChNine);
  assign is_sign = (rx_byte == ChPlus) || (rx_byte == ChMinus);
  assign dval = rx_byte[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP1;
      len <= '0;
      mag1 <= '0;
      mag2 <= '0;
      neg1 <= 1'b0;
      neg2 <= 1'b0;
    end else begin
      phase <= phase_next;
      len <= len_next;
      mag1 <= mag1_next;
      mag2 <= mag2_next;
      neg1 <= neg1_next;
      neg2 <= neg2_next;
    end
  end

  always_comb begin
    phase_next = phase;
    len_next = len;
    mag1_next = mag1;
    mag2_next = mag2;
    neg1_next = neg1;
    neg2_next = neg2;
    push = 1'b0;
    rec.pan = mag1;
    rec.tilt = mag2;
    if (phase != PH_DIG2 && phase != PH_DONE) begin
      rec.status = ST_MALFORMED;
    end else if (!angle_ok(mag1, neg1) || !angle_ok(mag2, neg2)) begin
      rec.status = ST_RANGE;
    end else begin
      rec.status = ST_OK;
    end
    if (rx_valid && rx_ready) begin
      if (is_nl || len == LineMaxLen) begin
        // end of line: push the record and restart; overflow: drop the partial line
        push = is_nl;
        phase_next = PH_SKIP1;
        len_next = '0;
        mag1_next = '0;
        mag2_next = '0;
        neg1_next = 1'b0;
        neg2_next = 1'b0;
      end else begin
        len_next = len + 1'b1;
        case (phase)
          PH_SKIP1: begin
            if (!is_space) begin
              if (is_sign) begin
                neg1_next = (rx_byte == ChMinus);
                phase_next = PH_SIGN1;
              end else if (is_digit) begin
                mag1_next = add_digit('0, dval);
                phase_next = PH_DIG1;
              end else begin
                phase_next = PH_FAIL;
              end
            end
          end
          PH_SIGN1: begin
            if (is_digit) begin
              mag1_next = add_digit('0, dval);
              phase_next = PH_DIG1;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_DIG1: begin
            if (is_digit) begin
              mag1_next = add_digit(mag1, dval);
            end else if (rx_byte == ChComma) begin
              phase_next = PH_SKIP2;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_SKIP2: begin
            if (!is_space) begin
              if (is_sign) begin
                neg2_next = (rx_byte == ChMinus);
                phase_next = PH_SIGN2;
              end else if (is_digit) begin
                mag2_next = add_digit('0, dval);
                phase_next = PH_DIG2;
              end else begin
                phase_next = PH_FAIL;
              end
            end
          end
          PH_SIGN2: begin
            if (is_digit) begin
              mag2_next = add_digit('0, dval);
              phase_next = PH_DIG2;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_DIG2: begin
            if (is_digit) begin
              mag2_next = add_digit(mag2, dval);
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[hw/rtl/sap_queue.sv]
module sap_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sap_pkg::line_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output sap_pkg::line_rec_t pop_rec,
  output logic               empty
);
  import sap_pkg::*;

  line_rec_t mem [QueueDepth];
  logic [QueueAw-1:0] wr, rd;
  logic [QueueAw:0] count;

  assign full = (count == (QueueAw+1)'(QueueDepth));
  assign empty = (count == '0);
  assign pop_rec = mem[rd];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= wr + 1'b1;
      end
      if (pop) begin
        rd <= rd + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/sap_back.sv]
module sap_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  sap_pkg::line_rec_t            rec,
  output logic                          pop,
  input  logic [sap_pkg::CfgW-1:0]      pulse_min,
  input  logic [sap_pkg::CfgW-1:0]      pulse_span,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    status,
  output logic [sap_pkg::AngleW-1:0]    pan_deg,
  output logic [sap_pkg::AngleW-1:0]    tilt_deg,
  output logic [sap_pkg::PulseW-1:0]    pan_pulse_us,
  output logic [sap_pkg::PulseW-1:0]    tilt_pulse_us
);
  import sap_pkg::*;

  logic en;
  logic a_valid, b_valid;
  status_t a_status, b_status;
  logic [AngleW-1:0] a_pan, a_tilt, b_pan, b_tilt;
  logic [ProdW-1:0] a_pan_prod, a_tilt_prod;
  logic [PulseW-1:0] b_pan_q, b_tilt_q;
  logic [AngleW-1:0] held_pan, held_tilt;
  logic [PulseW-1:0] held_pan_pulse, held_tilt_pulse;
  logic [PulseW-1:0] pan_pulse_next, tilt_pulse_next;
  logic take;

  assign en = !res_valid || res_ready;
  assign pop = en && !empty;
  assign take = b_valid && (b_status == ST_OK);
  assign pan_pulse_next = PulseW'(pulse_min) + b_pan_q;
  assign tilt_pulse_next = PulseW'(pulse_min) + b_tilt_q;

  always_ff @(posedge clk) begin
    if (en) begin
      a_status <= rec.status;
      a_pan <= rec.pan;
      a_tilt <= rec.tilt;
      a_pan_prod <= ProdW'(pulse_span) * ProdW'(rec.pan);
      a_tilt_prod <= ProdW'(pulse_span) * ProdW'(rec.tilt);
      b_status <= a_status;
      b_pan <= a_pan;
      b_tilt <= a_tilt;
      b_pan_q <= div180(a_pan_prod);
      b_tilt_q <= div180(a_tilt_prod);
      if (take) begin
        status <= ST_OK;
        pan_deg <= b_pan;
        tilt_deg <= b_tilt;
        pan_pulse_us <= pan_pulse_next;
        tilt_pulse_us <= tilt_pulse_next;
      end else begin
        status <= b_status;
        pan_deg <= held_pan;
        tilt_deg <= held_tilt;
        pan_pulse_us <= held_pan_pulse;
        tilt_pulse_us <= held_tilt_pulse;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      res_valid <= 1'b0;
      held_pan <= AngleReset;
      held_tilt <= AngleReset;
      held_pan_pulse <= PulseReset;
      held_tilt_pulse <= PulseReset;
    end else if (en) begin
      a_valid <= pop;
      b_valid <= a_valid;
      res_valid <= b_valid;
      if (take) begin
        held_pan <= b_pan;
        held_tilt <= b_tilt;
        held_pan_pulse <= pan_pulse_next;
        held_tilt_pulse <= tilt_pulse_next;
      end
    end
  end

endmodule

[hw/rtl/serial_angle_pair_to_servo_pulse.sv]
// Serial "pan,tilt" command parser with servo pulse width output.
// rx channel (rx_valid/rx_ready/rx_byte): one received byte per transfer,
// up to one per cycle. Non-newline bytes update the line parser and give
// no result; a newline closes the line and yields exactly one result.
// res channel (res_valid/res_ready): status plus the angles and pulse
// widths in force after that line. Pulse = min + span*angle/180.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes the
// minimum pulse, index 1 the span; other indexes are ignored. Always ready.
// A result passes the queue, the multiply and reciprocal divide registers and
// the output register before res_valid. Throughput: one byte per cycle while
// rx_ready holds, one result per cycle when res_ready holds.
// A four-entry line queue sits between parser and pulse pipeline; when the
// receiver stalls the pipeline holds, the queue fills, and rx_ready drops
// only once four more lines are waiting.
// Reset: angles 90, pulses 1500 us, min 500 us, span 2000 us, parser at
// start of line.
`include "serial_angle_pair_to_servo_pulse_assert.svh"

module serial_angle_pair_to_servo_pulse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [1:0]                 status,
  output logic [sap_pkg::AngleW-1:0] pan_deg,
  output logic [sap_pkg::AngleW-1:0] tilt_deg,
  output logic [sap_pkg::PulseW-1:0] pan_pulse_us,
  output logic [sap_pkg::PulseW-1:0] tilt_pulse_us,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [sap_pkg::CfgW-1:0]   cfg_data
);
  import sap_pkg::*;

  logic [CfgW-1:0] pulse_min, pulse_span;
  logic q_full, q_empty, q_push, q_pop;
  line_rec_t push_rec, pop_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min <= PulseMinReset;
      pulse_span <= PulseSpanReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PULSE_MIN: pulse_min <= cfg_data;
        CFG_PULSE_SPAN: pulse_span <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sap_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_ready (rx_ready),
    .full     (q_full),
    .push     (q_push),
    .rec      (push_rec)
  );

  sap_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  sap_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (q_empty),
    .rec           (pop_rec),
    .pop           (q_pop),
    .pulse_min     (pulse_min),
    .pulse_span    (pulse_span),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .status        (status),
    .pan_deg       (pan_deg),
    .tilt_deg      (tilt_deg),
    .pan_pulse_us  (pan_pulse_us),
    .tilt_pulse_us (tilt_pulse_us)
  );

  `SAP_ASSERT_IMPLIES(a_status_code, res_valid, status <= ST_RANGE)
  `SAP_ASSERT_IMPLIES(a_angle_range, res_valid, pan_deg <= AngleMax && tilt_deg <= AngleMax)
  `SAP_ASSERT_IMPLIES(a_no_push_full, q_full, !q_push)

endmodule
